FILE: rtl/afc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types for the box/frustum culling pipeline.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int NORMAL_WIDTH_DEF = 12;
    localparam int NUM_PLANES       = 6;
    localparam int CFG_WIDTH        = 64;
    localparam int CFG_INDEX_WIDTH  = 3;

    // register indexes on the config port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_BOTTOM = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE_FAR    = 3'd5;

    // load enables of the pipeline stages that live inside the plane units
    typedef struct packed {
        logic b;
        logic c;
        logic d;
        logic e;
    } t_pipe_en;

endpackage
`default_nettype wire

FILE: rtl/afc_plane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afc_plane
// One plane of the frustum: corner products, extreme corner dots, sphere sum
// and the final compares, spread over pipeline stages B to E.
// ----------------------------------------------------------------------------
module afc_plane
    import afc_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire t_pipe_en                      i_en,
    input  wire logic [CFG_WIDTH-1:0]          i_plane,
    input  wire logic signed [COORD_WIDTH-1:0] i_lo [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_hi [3],
    input  wire logic signed [COORD_WIDTH+2:0] i_m3,
    output logic                               o_sphere,
    output logic                               o_front,
    output logic                               o_behind
);

    localparam int CW   = COORD_WIDTH;
    localparam int NW   = NORMAL_WIDTH;
    localparam int NF   = NW - 2;
    localparam int PW   = CW + NW;
    localparam int OW   = CFG_WIDTH - 3 * NW;
    localparam int W1   = PW + 4;
    localparam int W2   = OW + NF + 3;
    localparam int W3   = CW + NF + 4;
    localparam int W12  = (W1 > W2) ? W1 : W2;
    localparam int CMPW = ((W12 > W3) ? W12 : W3) + 1;

    logic signed [NW-1:0] nrm [3];
    logic signed [OW-1:0] ofs;

    logic signed [PW-1:0]   n_pl [3];
    logic signed [PW-1:0]   n_ph [3];
    logic signed [PW-1:0]   r_pl [3];
    logic signed [PW-1:0]   r_ph [3];
    logic signed [PW-1:0]   r_big [3];
    logic signed [PW-1:0]   r_sml [3];
    logic signed [PW:0]     r_pair [3];
    logic signed [PW+2:0]   r_s;
    logic signed [PW+1:0]   r_dmax;
    logic signed [PW+1:0]   r_dmin;

    logic signed [CMPW-1:0] dq;
    logic signed [CMPW-1:0] lhs;
    logic signed [CMPW-1:0] rhs;
    logic signed [CMPW-1:0] dmax_x;
    logic signed [CMPW-1:0] dmin_x;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nrm[k]  = i_plane[k*NW +: NW];
            n_pl[k] = PW'(i_lo[k]) * PW'(nrm[k]);
            n_ph[k] = PW'(i_hi[k]) * PW'(nrm[k]);
        end
        ofs = i_plane[CFG_WIDTH-1:3*NW];
    end

    // stage B: products of both corners with the normal
    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            r_pl <= n_pl;
            r_ph <= n_ph;
        end
    end

    // stage C: per-axis larger and smaller term, and the midpoint sum term
    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            for (int k = 0; k < 3; k++) begin
                r_big[k]  <= (r_pl[k] > r_ph[k]) ? r_pl[k] : r_ph[k];
                r_sml[k]  <= (r_pl[k] > r_ph[k]) ? r_ph[k] : r_pl[k];
                r_pair[k] <= (PW+1)'(r_pl[k]) + (PW+1)'(r_ph[k]);
            end
        end
    end

    // stage D: most-in-front and most-behind corner dots, sphere dot sum
    always_ff @(posedge i_clk) begin
        if (i_en.d) begin
            r_s    <= (PW+3)'(r_pair[0]) + (PW+3)'(r_pair[1]) + (PW+3)'(r_pair[2]);
            r_dmax <= (PW+2)'(r_big[0]) + (PW+2)'(r_big[1]) + (PW+2)'(r_big[2]);
            r_dmin <= (PW+2)'(r_sml[0]) + (PW+2)'(r_sml[1]) + (PW+2)'(r_sml[2]);
        end
    end

    // stage E: compares, all scaled to product units
    always_comb begin
        dq     = CMPW'(ofs) <<< NF;
        lhs    = CMPW'(r_s) <<< 1;
        rhs    = (dq <<< 2) - (CMPW'(i_m3) <<< NF);
        dmax_x = CMPW'(r_dmax);
        dmin_x = CMPW'(r_dmin);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.e) begin
            o_sphere <= lhs > rhs;
            o_front  <= dmax_x > dq;
            o_behind <= dmin_x < dq;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/aabb_frustum_cull.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Tests an axis-aligned box against six configured planes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with the two box corners. A word is
//   taken on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_visible and o_fully_visible.
//   Config: i_cfg_we writes i_cfg_data to the plane selected by i_cfg_index
//   (near, right, left, top, bottom, far). Indexes 6 and 7 are dropped.
//   Write planes only while the pipeline is empty.
// Timing:
//   Six register stages (input, products, extremes, sums, compares, output);
//   a word passes through them in that order to o_valid.
//   One word per cycle sustained while i_stall is low; the per-axis
//   multipliers of each plane unit are fully pipelined.
// Reset: clears all valid bits and the six planes to zero.
// Stall: a held i_stall freezes the output word. Stages ahead of it keep
//   filling bubbles, so o_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module aabb_frustum_cull
    import afc_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_min_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_max_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_max_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_max_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_visible,
    output logic                               o_fully_visible,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]          i_cfg_data
);

    localparam int CW = COORD_WIDTH;

    logic [CFG_WIDTH-1:0] r_plane [NUM_PLANES];

    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    t_pipe_en pen;

    logic signed [CW-1:0] r_lo [3];
    logic signed [CW-1:0] r_hi [3];
    logic signed [CW:0]   r_diff [3];
    logic signed [CW:0]   r_m;
    logic signed [CW+2:0] r_m3;

    logic [NUM_PLANES-1:0] w_sph;
    logic [NUM_PLANES-1:0] w_front;
    logic [NUM_PLANES-1:0] w_behind;

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PLANE_NEAR:   r_plane[0] <= i_cfg_data;
                REG_PLANE_RIGHT:  r_plane[1] <= i_cfg_data;
                REG_PLANE_LEFT:   r_plane[2] <= i_cfg_data;
                REG_PLANE_TOP:    r_plane[3] <= i_cfg_data;
                REG_PLANE_BOTTOM: r_plane[4] <= i_cfg_data;
                REG_PLANE_FAR:    r_plane[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on
    always_comb begin
        rdy_f   = !o_valid || !i_stall;
        rdy_e   = !r_ve || rdy_f;
        rdy_d   = !r_vd || rdy_e;
        rdy_c   = !r_vc || rdy_d;
        rdy_b   = !r_vb || rdy_c;
        rdy_a   = !r_va || rdy_b;
        o_stall = !rdy_a;
        pen.b   = rdy_b;
        pen.c   = rdy_c;
        pen.d   = rdy_d;
        pen.e   = rdy_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
            r_ve    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (rdy_a) r_va    <= i_valid;
            if (rdy_b) r_vb    <= r_va;
            if (rdy_c) r_vc    <= r_vb;
            if (rdy_d) r_vd    <= r_vc;
            if (rdy_e) r_ve    <= r_vd;
            if (rdy_f) o_valid <= r_ve;
        end
    end

    // stage A: capture corners
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_lo[0] <= i_min_x;
            r_lo[1] <= i_min_y;
            r_lo[2] <= i_min_z;
            r_hi[0] <= i_max_x;
            r_hi[1] <= i_max_y;
            r_hi[2] <= i_max_z;
        end
    end

    // stages B-D: doubled extents, their true max, then three times that
    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            for (int k = 0; k < 3; k++) begin
                r_diff[k] <= (CW+1)'(r_hi[k]) - (CW+1)'(r_lo[k]);
            end
        end
        if (rdy_c) begin
            if (r_diff[0] >= r_diff[1] && r_diff[0] >= r_diff[2]) begin
                r_m <= r_diff[0];
            end else if (r_diff[1] >= r_diff[2]) begin
                r_m <= r_diff[1];
            end else begin
                r_m <= r_diff[2];
            end
        end
        if (rdy_d) begin
            r_m3 <= ((CW+3)'(r_m) <<< 1) + (CW+3)'(r_m);
        end
    end

    for (genvar gp = 0; gp < NUM_PLANES; gp++) begin : g_plane
        afc_plane #(
            .COORD_WIDTH  (COORD_WIDTH),
            .NORMAL_WIDTH (NORMAL_WIDTH)
        ) u_plane (
            .i_clk    (i_clk),
            .i_en     (pen),
            .i_plane  (r_plane[gp]),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .i_m3     (r_m3),
            .o_sphere (w_sph[gp]),
            .o_front  (w_front[gp]),
            .o_behind (w_behind[gp])
        );
    end

    // stage F: combine the six planes
    always_ff @(posedge i_clk) begin
        if (rdy_f) begin
            o_visible       <= (&w_sph) & (&w_front);
            o_fully_visible <= (&w_sph) & ~(|w_behind);
        end
    end

endmodule
`default_nettype wire
